// ----- hdl/sgmd_pkg.sv -----
// Shared types, constants and helper functions for the sensor grid move detector.
package sgmd_pkg;

  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned SEL_W     = 4;
  localparam int unsigned BANK_W    = 2;
  localparam int unsigned COORD_W   = 3;
  localparam int unsigned SQUARES   = 64;
  localparam int unsigned SQ_IDX_W  = $clog2(SQUARES);
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned CLS_W     = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [COUNT_W-1:0]   COUNT_MAX     = COUNT_W'(SQUARES);
  localparam logic [COUNT_W-1:0]   MOVE_CHANGES  = COUNT_W'(2);
  localparam logic [SAMPLE_W-1:0]  HIGH_THR_RST  = SAMPLE_W'(700);
  localparam logic [SAMPLE_W-1:0]  LOW_THR_RST   = SAMPLE_W'(300);
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR   = CFG_IDX_W'(1);

  typedef enum logic [CLS_W-1:0] {
    CLS_EMPTY = 2'd0,
    CLS_WHITE = 2'd1,
    CLS_BLACK = 2'd2
  } cls_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [SEL_W-1:0]    mux_select;
    logic [BANK_W-1:0]   bank;
    logic                end_of_scan;
  } in_beat_t;

  typedef struct packed {
    logic [COORD_W-1:0] vacated_row;
    logic [COORD_W-1:0] vacated_col;
    logic               vacated_seen;
    logic [COORD_W-1:0] filled_row;
    logic [COORD_W-1:0] filled_col;
    logic               filled_seen;
    logic [COUNT_W-1:0] change_count;
    logic               move_valid;
  } out_beat_t;

  typedef struct packed {
    logic                fire;
    logic                changed;
    logic                vacate;
    logic [SQ_IDX_W-1:0] idx;
    logic                report;
  } tally_evt_t;

  typedef struct packed {
    logic [SQ_IDX_W-1:0] idx;
    cls_t                cls;
    logic                eos;
  } sq_item_t;

  // Row-major square index: row = {bank[1], sel[1:0]}, col = {bank[0], ~sel[3:2]}.
  function automatic logic [SQ_IDX_W-1:0] square_index(input logic [SEL_W-1:0] sel,
                                                       input logic [BANK_W-1:0] bank);
    square_index = {bank[1], sel[1:0], bank[0], ~sel[3:2]};
  endfunction

  function automatic cls_t classify(input logic [SAMPLE_W-1:0] s,
                                    input logic [SAMPLE_W-1:0] high_thr,
                                    input logic [SAMPLE_W-1:0] low_thr);
    cls_t c;
    priority if (s > high_thr) begin
      c = CLS_WHITE;
    end else if (s < low_thr) begin
      c = CLS_BLACK;
    end else begin
      c = CLS_EMPTY;
    end
    classify = c;
  endfunction

endpackage

// ----- hdl/sensor_grid_move_detector_core.sv -----
// Top level of the sensor grid move detector: input stage, square store and result register.
//
//   channel | direction | handshake           | beat
//   in_     | input     | in_valid / in_stall | sgmd_pkg::in_beat_t
//   out_    | output    | out_valid/out_stall | sgmd_pkg::out_beat_t
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Beats are accepted one per cycle unless an end-of-scan beat waits on a held result.
// The rate is set by the single read and single write port of the 64-entry square store.
// Synchronous reset marks every square empty at once through per-square valid bits.
// A stalled result holds back an end-of-scan beat and every beat behind it; other beats flow.
// The configuration port is always ready.
module sensor_grid_move_detector_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sgmd_pkg::in_beat_t                in_beat,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sgmd_pkg::out_beat_t               out_beat,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sgmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sgmd_pkg::SAMPLE_W-1:0]     cfg_data
);

  logic [sgmd_pkg::SAMPLE_W-1:0] high_thr_r, low_thr_r;
  logic                          in_accept;
  logic                          retire;
  sgmd_pkg::sq_item_t            new_item;
  sgmd_pkg::sq_item_t            s1_r;
  logic                          s1_vld_r;
  logic [sgmd_pkg::SQUARES-1:0]  sq_vld_r;
  logic                          vld_rd_r;
  logic                          fwd_hit_r;
  sgmd_pkg::cls_t                fwd_cls_r;
  logic [sgmd_pkg::CLS_W-1:0]    rd_data;
  sgmd_pkg::cls_t                old_cls;
  sgmd_pkg::tally_evt_t          evt;
  sgmd_pkg::out_beat_t           report;
  logic                          out_valid_r;
  sgmd_pkg::out_beat_t           out_beat_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r <= sgmd_pkg::HIGH_THR_RST;
      low_thr_r  <= sgmd_pkg::LOW_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sgmd_pkg::CFG_HIGH_THR: high_thr_r <= cfg_data;
        sgmd_pkg::CFG_LOW_THR:  low_thr_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // An end-of-scan beat can only leave the stage when the result register is free.
  assign retire    = s1_vld_r && (!s1_r.eos || !out_valid_r || !out_stall);
  assign in_stall  = s1_vld_r && !retire;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    new_item.idx = sgmd_pkg::square_index(in_beat.mux_select, in_beat.bank);
    new_item.cls = sgmd_pkg::classify(in_beat.sample, high_thr_r, low_thr_r);
    new_item.eos = in_beat.end_of_scan;
  end

  sgmd_ram #(
    .WIDTH (sgmd_pkg::CLS_W),
    .DEPTH (sgmd_pkg::SQUARES)
  ) u_store (
    .clk     (clk),
    .we      (retire),
    .waddr   (s1_r.idx),
    .wdata   (s1_r.cls),
    .re      (in_accept),
    .raddr   (new_item.idx),
    .rdata_r (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      sq_vld_r  <= '0;
      vld_rd_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_vld_r  <= 1'b1;
        vld_rd_r  <= sq_vld_r[new_item.idx];
        fwd_hit_r <= retire && (s1_r.idx == new_item.idx);
      end else if (retire) begin
        s1_vld_r <= 1'b0;
      end
      if (retire) begin
        sq_vld_r[s1_r.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r      <= new_item;
      fwd_cls_r <= s1_r.cls;
    end
  end

  // The store reads before it writes, so a square written in the read cycle comes from the bypass.
  always_comb begin
    priority if (fwd_hit_r) begin
      old_cls = fwd_cls_r;
    end else if (vld_rd_r) begin
      old_cls = sgmd_pkg::cls_t'(rd_data);
    end else begin
      old_cls = sgmd_pkg::CLS_EMPTY;
    end
  end

  always_comb begin
    evt.fire    = retire;
    evt.changed = (s1_r.cls != old_cls);
    evt.vacate  = (s1_r.cls == sgmd_pkg::CLS_EMPTY);
    evt.idx     = s1_r.idx;
    evt.report  = s1_r.eos;
  end

  sgmd_tally u_tally (
    .clk    (clk),
    .rst_n  (rst_n),
    .evt    (evt),
    .report (report)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (retire && s1_r.eos) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire && s1_r.eos) begin
      out_beat_r <= report;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("input stalled with an empty stage");

  a_blocked_report_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_r.eos && out_valid_r && out_stall) |-> in_stall)
    else $error("end-of-scan beat retired over a held result");

  a_report_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (retire && s1_r.eos) |=> out_valid_r)
    else $error("retired end-of-scan beat produced no result");

endmodule

// ----- hdl/sgmd_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module sgmd_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ----- hdl/sgmd_tally.sv -----
// Per-scan change counter and highest vacated and filled square tracking.
module sgmd_tally (
  input  logic                clk,
  input  logic                rst_n,
  input  sgmd_pkg::tally_evt_t evt,
  output sgmd_pkg::out_beat_t  report
);

  logic [sgmd_pkg::COUNT_W-1:0]  count_r, count_nxt, count_upd;
  logic [sgmd_pkg::SQ_IDX_W-1:0] vidx_r, vidx_nxt, vidx_upd;
  logic [sgmd_pkg::SQ_IDX_W-1:0] fidx_r, fidx_nxt, fidx_upd;
  logic                          vflag_r, vflag_nxt, vflag_upd;
  logic                          fflag_r, fflag_nxt, fflag_upd;

  always_comb begin
    count_upd = count_r;
    vidx_upd  = vidx_r;
    vflag_upd = vflag_r;
    fidx_upd  = fidx_r;
    fflag_upd = fflag_r;
    if (evt.fire && evt.changed) begin
      if (count_r != sgmd_pkg::COUNT_MAX) begin
        count_upd = count_r + sgmd_pkg::COUNT_W'(1);
      end
      if (evt.vacate) begin
        if (!vflag_r || (evt.idx > vidx_r)) begin
          vidx_upd = evt.idx;
        end
        vflag_upd = 1'b1;
      end else begin
        if (!fflag_r || (evt.idx > fidx_r)) begin
          fidx_upd = evt.idx;
        end
        fflag_upd = 1'b1;
      end
    end
  end

  always_comb begin
    report.vacated_row  = vidx_upd[5:3];
    report.vacated_col  = vidx_upd[2:0];
    report.vacated_seen = vflag_upd;
    report.filled_row   = fidx_upd[5:3];
    report.filled_col   = fidx_upd[2:0];
    report.filled_seen  = fflag_upd;
    report.change_count = count_upd;
    report.move_valid   = (count_upd == sgmd_pkg::MOVE_CHANGES);
  end

  always_comb begin
    if (evt.fire && evt.report) begin
      count_nxt = '0;
      vidx_nxt  = '0;
      vflag_nxt = 1'b0;
      fidx_nxt  = '0;
      fflag_nxt = 1'b0;
    end else begin
      count_nxt = count_upd;
      vidx_nxt  = vidx_upd;
      vflag_nxt = vflag_upd;
      fidx_nxt  = fidx_upd;
      fflag_nxt = fflag_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      vidx_r  <= '0;
      vflag_r <= 1'b0;
      fidx_r  <= '0;
      fflag_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      vidx_r  <= vidx_nxt;
      vflag_r <= vflag_nxt;
      fidx_r  <= fidx_nxt;
      fflag_r <= fflag_nxt;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sgmd_pkg::COUNT_MAX)
    else $error("change count exceeds the number of squares");

  a_vacated_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !vflag_r |-> (vidx_r == '0))
    else $error("vacated index set without a vacated square");

endmodule
